/* hdl/sss_pkg.sv */
// ----------------------------------------------------------------------------
// sss_pkg
// Shared widths, constants and types of the servo stroke sequencer: the
// configuration record, the stroke phase codes, the register indexes and the
// record handed from the control stage to the servo mixing stages.
// ----------------------------------------------------------------------------
package sss_pkg;

   localparam int TIME_BITS      = 32;
   localparam int AXIS_BITS      = 16;
   localparam int ANGLE_BITS     = 9;
   localparam int PHASE_BITS     = 3;
   localparam int GAIN_BITS      = 9;
   localparam int CYCLE_BITS     = 4;
   localparam int TICK_BITS      = 10;
   localparam int MS_BITS        = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Full-scale axis value, 2^(AXIS_BITS-1)-1.
   localparam int AXIS_FULL = 2 ** (AXIS_BITS - 1) - 1;

   localparam logic [ANGLE_BITS-1:0] HOME_DEG = ANGLE_BITS'(150);
   localparam logic [ANGLE_BITS-1:0] MAX_DEG  = ANGLE_BITS'(270);

   typedef enum logic [PHASE_BITS-1:0] {
      PH_IDLE,
      PH_PREPOSE,
      PH_CONTRACT,
      PH_GLIDE,
      PH_RETRACT,
      PH_HOLD
   } phase_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TICK_PERIOD,
      CSR_STICK_GAIN,
      CSR_CYCLES,
      CSR_GLIDE,
      CSR_RETURN_HOLD,
      CSR_RETRACT_STEP,
      CSR_RETRACT_INTERVAL,
      CSR_CONTRACT_DELTA
   } csr_index_type;

   typedef struct packed {
      logic [TICK_BITS-1:0]  tick_period_ms;
      logic [GAIN_BITS-1:0]  stick_gain;
      logic [CYCLE_BITS-1:0] stroke_repeats;
      logic [MS_BITS-1:0]    dwell_ms;
      logic [MS_BITS-1:0]    rest_ms;
      logic [ANGLE_BITS-1:0] retract_step_deg;
      logic [MS_BITS-1:0]    retract_interval_ms;
      logic [ANGLE_BITS-1:0] contract_span;
   } cfg_type;

   // One valid tick leaving the control stage.
   typedef struct packed {
      logic                        valid;
      logic [ANGLE_BITS-1:0]       base;
      logic signed [AXIS_BITS-1:0] stick_x;
      logic signed [AXIS_BITS-1:0] stick_y;
      logic [ANGLE_BITS-1:0]       stroke;
      phase_type                   phase;
   } mix_type;

endpackage

/* hdl/sss_if.sv */
// ----------------------------------------------------------------------------
// sss_req_if / sss_rsp_if
// Valid/ready channels of the servo stroke sequencer: control ticks in,
// servo angle sets out.
// ----------------------------------------------------------------------------
interface sss_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 joy_valid;
   logic signed [sss_pkg::AXIS_BITS-1:0] stick_x;
   logic signed [sss_pkg::AXIS_BITS-1:0] stick_y;
   logic signed [sss_pkg::AXIS_BITS-1:0] trigger;
   logic                                 trim_up;
   logic                                 trim_down;
   logic                                 start_button;
   logic                                 stop_button;

   modport source (
      output valid, joy_valid, stick_x, stick_y, trigger,
             trim_up, trim_down, start_button, stop_button,
      input  ready
   );
   modport sink (
      input  valid, joy_valid, stick_x, stick_y, trigger,
             trim_up, trim_down, start_button, stop_button,
      output ready
   );
endinterface

interface sss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [sss_pkg::ANGLE_BITS-1:0]  servo1_angle;
   logic [sss_pkg::ANGLE_BITS-1:0]  servo2_angle;
   logic [sss_pkg::ANGLE_BITS-1:0]  servo3_angle;
   logic [sss_pkg::ANGLE_BITS-1:0]  servo4_angle;
   logic [sss_pkg::ANGLE_BITS-1:0]  servo5_angle;
   logic [sss_pkg::PHASE_BITS-1:0]  phase;

   modport source (
      output valid, servo1_angle, servo2_angle, servo3_angle, servo4_angle,
             servo5_angle, phase,
      input  ready
   );
   modport sink (
      input  valid, servo1_angle, servo2_angle, servo3_angle, servo4_angle,
             servo5_angle, phase,
      output ready
   );
endinterface

/* hdl/sss_csr.sv */
// ----------------------------------------------------------------------------
// sss_csr
// Configuration registers, written through a plain write port and held in
// one record for the rest of the block.
// ----------------------------------------------------------------------------
module sss_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [sss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sss_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output sss_pkg::cfg_type                   cfg
);

   sss_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tick_period_ms      <= sss_pkg::TICK_BITS'(20);
         cfg_ff.stick_gain          <= sss_pkg::GAIN_BITS'(135);
         cfg_ff.stroke_repeats      <= sss_pkg::CYCLE_BITS'(3);
         cfg_ff.dwell_ms            <= sss_pkg::MS_BITS'(1000);
         cfg_ff.rest_ms             <= sss_pkg::MS_BITS'(150);
         cfg_ff.retract_step_deg    <= sss_pkg::ANGLE_BITS'(4);
         cfg_ff.retract_interval_ms <= sss_pkg::MS_BITS'(20);
         cfg_ff.contract_span       <= sss_pkg::ANGLE_BITS'(400);
      end else if (csr_we) begin
         unique case (sss_pkg::csr_index_type'(csr_index))
            sss_pkg::CSR_TICK_PERIOD: begin
               cfg_ff.tick_period_ms <= csr_wdata[sss_pkg::TICK_BITS-1:0];
            end
            sss_pkg::CSR_STICK_GAIN: begin
               cfg_ff.stick_gain <= csr_wdata[sss_pkg::GAIN_BITS-1:0];
            end
            sss_pkg::CSR_CYCLES: begin
               cfg_ff.stroke_repeats <= csr_wdata[sss_pkg::CYCLE_BITS-1:0];
            end
            sss_pkg::CSR_GLIDE: begin
               cfg_ff.dwell_ms <= csr_wdata[sss_pkg::MS_BITS-1:0];
            end
            sss_pkg::CSR_RETURN_HOLD: begin
               cfg_ff.rest_ms <= csr_wdata[sss_pkg::MS_BITS-1:0];
            end
            sss_pkg::CSR_RETRACT_STEP: begin
               cfg_ff.retract_step_deg <= csr_wdata[sss_pkg::ANGLE_BITS-1:0];
            end
            sss_pkg::CSR_RETRACT_INTERVAL: begin
               cfg_ff.retract_interval_ms <= csr_wdata[sss_pkg::MS_BITS-1:0];
            end
            sss_pkg::CSR_CONTRACT_DELTA: begin
               cfg_ff.contract_span <= csr_wdata[sss_pkg::ANGLE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/sss_ctrl.sv */
// ----------------------------------------------------------------------------
// sss_ctrl
// Control stage: advances the tick clock, trims the base angle, detects the
// button edges and steps the stroke sequence for servo 5, all in the cycle
// an item is accepted. Valid ticks are passed on to the mixing stages.
// ----------------------------------------------------------------------------
module sss_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  sss_pkg::cfg_type  cfg,
   sss_req_if.sink           req,
   output sss_pkg::mix_type  mix
);

   localparam int TB = sss_pkg::TIME_BITS;
   localparam int AB = sss_pkg::ANGLE_BITS;
   localparam int TRIG_BITS  = sss_pkg::AXIS_BITS + 5;
   localparam int TRIG_LIMIT = 9 * sss_pkg::AXIS_FULL;
   localparam logic [AB-1:0] IDLE_STEP = AB'(10);

   logic [TB-1:0]                  time_ff, time_in;
   logic [TB-1:0]                  pdl_ff, pdl_in;
   logic [TB-1:0]                  rdl_ff, rdl_in;
   logic [AB-1:0]                  base_ff, base_in;
   logic [AB-1:0]                  stroke_ff, stroke_in;
   logic [AB-1:0]                  contract_ff, contract_in;
   logic [sss_pkg::CYCLE_BITS-1:0] cycles_ff, cycles_in;
   sss_pkg::phase_type             phase_ff, phase_in;
   logic                           last_start_ff, last_start_in;
   logic                           last_stop_ff, last_stop_in;
   sss_pkg::mix_type               mix_ff, mix_in;

   // Travel time ceil(d/18)*2+80 ms; the divide by 18 is a multiply by
   // 57/1024, exact for every sum below 288.
   function automatic logic [7:0] travel_ms(logic [AB-1:0] from, logic [AB-1:0] to);
      logic [AB-1:0] d;
      logic [AB:0]   v;
      logic [15:0]   p;
      d = (to > from) ? to - from : from - to;
      v = {1'b0, d} + (AB + 1)'(17);
      p = 16'(v) * 16'(57);
      return 8'({p[14:10], 1'b0}) + 8'(80);
   endfunction

   // Wrap-safe deadline test.
   function automatic logic reached(logic [TB-1:0] now, logic [TB-1:0] dl);
      logic [TB-1:0] diff;
      diff = now - dl;
      return !diff[TB-1];
   endfunction

   assign req.ready = adv;

   always_comb begin : next_state
      logic                        take;
      logic [TB-1:0]               now;
      logic                        start_edge;
      logic                        stop_edge;
      logic [AB:0]                 csum;
      logic [AB-1:0]               ca_new;
      logic signed [TRIG_BITS-1:0] trig_w;
      logic signed [TRIG_BITS-1:0] trig10;
      logic                        trig_low;
      logic [AB:0]                 up10;
      logic [AB-1:0]               gap;
      logic [AB-1:0]               st;

      take       = req.valid && adv;
      now        = time_ff + TB'(cfg.tick_period_ms);
      start_edge = req.start_button && !last_start_ff;
      stop_edge  = req.stop_button && !last_stop_ff;
      csum       = {1'b0, sss_pkg::HOME_DEG} + {1'b0, cfg.contract_span};
      ca_new     = (csum > {1'b0, sss_pkg::MAX_DEG}) ? sss_pkg::MAX_DEG : csum[AB-1:0];
      trig_w     = TRIG_BITS'(req.trigger);
      trig10     = (trig_w <<< 3) + (trig_w <<< 1);
      trig_low   = trig10 < $signed(TRIG_BITS'(TRIG_LIMIT));
      st         = cfg.retract_step_deg;
      up10       = '0;
      gap        = '0;

      time_in       = time_ff;
      pdl_in        = pdl_ff;
      rdl_in        = rdl_ff;
      base_in       = base_ff;
      stroke_in     = stroke_ff;
      contract_in   = contract_ff;
      cycles_in     = cycles_ff;
      phase_in      = phase_ff;
      last_start_in = last_start_ff;
      last_stop_in  = last_stop_ff;

      if (take) begin
         time_in = now;
      end

      if (take && req.joy_valid) begin
         last_start_in = req.start_button;
         last_stop_in  = req.stop_button;

         if (req.trim_up) begin
            if (base_ff < sss_pkg::MAX_DEG) begin
               base_in = base_ff + AB'(1);
            end
         end else if (req.trim_down) begin
            if (base_ff != '0) begin
               base_in = base_ff - AB'(1);
            end
         end

         if (start_edge) begin
            cycles_in = cfg.stroke_repeats;
            if (stroke_ff != sss_pkg::HOME_DEG) begin
               pdl_in    = now + TB'(travel_ms(stroke_ff, sss_pkg::HOME_DEG));
               stroke_in = sss_pkg::HOME_DEG;
               phase_in  = sss_pkg::PH_PREPOSE;
            end else begin
               contract_in = ca_new;
               pdl_in      = now + TB'(travel_ms(stroke_ff, ca_new));
               stroke_in   = ca_new;
               phase_in    = sss_pkg::PH_CONTRACT;
            end
         end

         if (stop_edge) begin
            phase_in  = sss_pkg::PH_IDLE;
            cycles_in = '0;
         end

         if (phase_in == sss_pkg::PH_IDLE) begin
            // Manual trigger control of servo 5.
            up10 = {1'b0, stroke_in} + {1'b0, IDLE_STEP};
            if (trig_low) begin
               stroke_in = (up10 > {1'b0, sss_pkg::MAX_DEG}) ? sss_pkg::MAX_DEG
                                                              : up10[AB-1:0];
            end else if (stroke_in > sss_pkg::HOME_DEG) begin
               stroke_in = (stroke_in - IDLE_STEP < sss_pkg::HOME_DEG) ? sss_pkg::HOME_DEG
                                                                      : stroke_in - IDLE_STEP;
            end else if (stroke_in < sss_pkg::HOME_DEG) begin
               stroke_in = (up10 > {1'b0, sss_pkg::HOME_DEG}) ? sss_pkg::HOME_DEG
                                                               : up10[AB-1:0];
            end
         end else if (!start_edge) begin
            // A fresh start sets deadlines in the future, so the sequence
            // only steps on ticks without a start press.
            case (phase_ff)
               sss_pkg::PH_PREPOSE: begin
                  if (reached(now, pdl_ff)) begin
                     contract_in = ca_new;
                     pdl_in      = now + TB'(travel_ms(stroke_ff, ca_new));
                     stroke_in   = ca_new;
                     phase_in    = sss_pkg::PH_CONTRACT;
                  end
               end
               sss_pkg::PH_CONTRACT: begin
                  if (reached(now, pdl_ff)) begin
                     pdl_in   = now + TB'(cfg.dwell_ms);
                     phase_in = sss_pkg::PH_GLIDE;
                  end
               end
               sss_pkg::PH_GLIDE: begin
                  if (reached(now, pdl_ff)) begin
                     rdl_in   = now;
                     phase_in = sss_pkg::PH_RETRACT;
                  end
               end
               sss_pkg::PH_RETRACT: begin
                  if (reached(now, rdl_ff)) begin
                     if (stroke_ff < sss_pkg::HOME_DEG) begin
                        gap       = sss_pkg::HOME_DEG - stroke_ff;
                        stroke_in = stroke_ff + ((st < gap) ? st : gap);
                     end else if (stroke_ff > sss_pkg::HOME_DEG) begin
                        gap       = stroke_ff - sss_pkg::HOME_DEG;
                        stroke_in = stroke_ff - ((st < gap) ? st : gap);
                     end
                     if (stroke_in == sss_pkg::HOME_DEG) begin
                        pdl_in   = now + TB'(cfg.rest_ms);
                        phase_in = sss_pkg::PH_HOLD;
                     end else begin
                        rdl_in = now + TB'(cfg.retract_interval_ms);
                     end
                  end
               end
               sss_pkg::PH_HOLD: begin
                  if (reached(now, pdl_ff)) begin
                     if (cycles_ff > sss_pkg::CYCLE_BITS'(1)) begin
                        cycles_in = cycles_ff - sss_pkg::CYCLE_BITS'(1);
                        pdl_in    = now + TB'(travel_ms(stroke_ff, contract_ff));
                        stroke_in = contract_ff;
                        phase_in  = sss_pkg::PH_CONTRACT;
                     end else begin
                        cycles_in = '0;
                        phase_in  = sss_pkg::PH_IDLE;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end

      mix_in.valid   = take && req.joy_valid;
      mix_in.base    = base_in;
      mix_in.stick_x = req.stick_x;
      mix_in.stick_y = req.stick_y;
      mix_in.stroke  = stroke_in;
      mix_in.phase   = phase_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff       <= '0;
         pdl_ff        <= '0;
         rdl_ff        <= '0;
         base_ff       <= sss_pkg::HOME_DEG;
         stroke_ff     <= sss_pkg::HOME_DEG;
         contract_ff   <= sss_pkg::HOME_DEG;
         cycles_ff     <= '0;
         phase_ff      <= sss_pkg::PH_IDLE;
         last_start_ff <= 1'b0;
         last_stop_ff  <= 1'b0;
         mix_ff.valid  <= 1'b0;
      end else begin
         time_ff       <= time_in;
         pdl_ff        <= pdl_in;
         rdl_ff        <= rdl_in;
         base_ff       <= base_in;
         stroke_ff     <= stroke_in;
         contract_ff   <= contract_in;
         cycles_ff     <= cycles_in;
         phase_ff      <= phase_in;
         last_start_ff <= last_start_in;
         last_stop_ff  <= last_stop_in;
         if (adv) begin
            mix_ff <= mix_in;
         end
      end
   end

   assign mix = mix_ff;

endmodule

/* hdl/sss_servo.sv */
// ----------------------------------------------------------------------------
// sss_servo
// Mixing stages: applies the stick deadzone and gain to the base angle for
// servos 1 to 4, scales back by the axis full scale and clamps, and holds
// the finished item in the output register.
// ----------------------------------------------------------------------------
module sss_servo (
   input  logic                            clock,
   input  logic                            reset,
   input  sss_pkg::mix_type                mix,
   input  logic [sss_pkg::GAIN_BITS-1:0]   gain,
   output logic                            adv,
   sss_rsp_if.source                       rsp
);

   localparam int XB  = sss_pkg::AXIS_BITS;
   localparam int AB  = sss_pkg::ANGLE_BITS;
   localparam int SB  = XB + 1;
   localparam int NB  = XB + AB + 2;
   localparam int QB  = NB - XB;
   localparam int DEAD_LIMIT = (sss_pkg::AXIS_FULL + 9) / 10;

   logic                         st2_valid_ff;
   logic signed [NB-1:0]         num_ff [4];
   logic [AB-1:0]                st2_stroke_ff;
   sss_pkg::phase_type           st2_phase_ff;

   logic                         out_valid_ff;
   logic [AB-1:0]                out_angle_ff [5];
   sss_pkg::phase_type           out_phase_ff;

   logic signed [NB-1:0]         num_in [4];
   logic [AB-1:0]                angle_in [4];

   // Stick values inside the deadzone count as zero.
   function automatic logic signed [SB-1:0] dead(logic signed [SB-1:0] s);
      logic [SB-1:0] a;
      a = s[SB-1] ? -s : s;
      return (a < SB'(DEAD_LIMIT)) ? '0 : s;
   endfunction

   // floor(num / (2^(XB-1)-1)), clamped to 0..270. The quotient is either
   // num >> (XB-1) or one more, settled by one remainder compare.
   function automatic logic [AB-1:0] scale(logic signed [NB-1:0] num);
      logic [NB-2:0] n;
      logic [QB-1:0] q_est;
      logic [XB:0]   r;
      logic [QB:0]   q;
      n     = num[NB-2:0];
      q_est = n[NB-2:XB-1];
      r     = (XB + 1)'(n[XB-2:0]) + (XB + 1)'(q_est);
      q     = {1'b0, q_est} + ((r >= (XB + 1)'(sss_pkg::AXIS_FULL)) ? (QB + 1)'(1) : '0);
      if (num[NB-1]) begin
         return '0;
      end else if (q > (QB + 1)'(sss_pkg::MAX_DEG)) begin
         return sss_pkg::MAX_DEG;
      end else begin
         return q[AB-1:0];
      end
   endfunction

   assign adv = !out_valid_ff || rsp.ready;

   always_comb begin : mix_math
      logic signed [SB-1:0] x;
      logic signed [SB-1:0] y;
      logic signed [NB-1:0] base_a;
      logic signed [NB-1:0] px;
      logic signed [NB-1:0] py;
      x      = dead(SB'(mix.stick_x));
      y      = dead(-SB'(mix.stick_y));
      base_a = $signed(NB'(mix.base) * NB'(sss_pkg::AXIS_FULL));
      px     = NB'(x) * NB'($signed({1'b0, gain}));
      py     = NB'(y) * NB'($signed({1'b0, gain}));
      num_in[0] = base_a + px;
      num_in[1] = base_a + py;
      num_in[2] = base_a - px;
      num_in[3] = base_a - py;
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         angle_in[i] = scale(num_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st2_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         st2_valid_ff  <= mix.valid;
         num_ff        <= num_in;
         st2_stroke_ff <= mix.stroke;
         st2_phase_ff  <= mix.phase;
         out_valid_ff  <= st2_valid_ff;
         for (int i = 0; i < 4; i++) begin
            out_angle_ff[i] <= angle_in[i];
         end
         out_angle_ff[4] <= st2_stroke_ff;
         out_phase_ff    <= st2_phase_ff;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.servo1_angle = out_angle_ff[0];
   assign rsp.servo2_angle = out_angle_ff[1];
   assign rsp.servo3_angle = out_angle_ff[2];
   assign rsp.servo4_angle = out_angle_ff[3];
   assign rsp.servo5_angle = out_angle_ff[4];
   assign rsp.phase        = sss_pkg::PHASE_BITS'(out_phase_ff);

endmodule

/* hdl/servo_stroke_sequencer.sv */
// ----------------------------------------------------------------------------
// servo_stroke_sequencer
// Each item on req_ch is one control tick carrying a joystick sample. The
// tick always advances the internal millisecond clock by tick_period_ms.
// A tick with joy_valid low changes nothing else and gives no result; a
// valid tick gives exactly one result on rsp_ch with the four stick servo
// angles, the stroke servo target and the current stroke phase.
// Configuration is written through csr_we/csr_index/csr_wdata, one register
// per clock; the user must write only with no item in flight; unenforced.
// Pipeline: a result passes the control register, the multiply register and
// the output register, in that order, before it is presented on rsp_ch.
// Throughput: one item per cycle while rsp_ch does not stall; all sequencing
// state is updated in the single cycle an item is taken.
// Stall: while rsp_ch holds a result that is not taken, the whole pipeline
// holds and req_ch.ready is low; req_ch.ready is high whenever the output
// register is empty or being emptied.
// Reset: configuration returns to its defaults, the clock and deadlines to
// zero, the base and stroke angles to 150 degrees, the sequence to idle.
// ----------------------------------------------------------------------------
module servo_stroke_sequencer (
   input  logic                               clock,
   input  logic                               reset,
   sss_req_if.sink                            req_ch,
   sss_rsp_if.source                          rsp_ch,
   input  logic                               csr_we,
   input  logic [sss_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [sss_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   sss_pkg::cfg_type cfg;
   sss_pkg::mix_type mix;
   logic             adv;

   sss_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sss_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .cfg   (cfg),
      .req   (req_ch),
      .mix   (mix)
   );

   sss_servo u_servo (
      .clock (clock),
      .reset (reset),
      .mix   (mix),
      .gain  (cfg.stick_gain),
      .adv   (adv),
      .rsp   (rsp_ch)
   );

endmodule
